// File: sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types, phase and command codes and the hold-time helper shared by the
// I2C master bit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  localparam int DATA_BITS = 8;
  localparam int HOLD_W    = 10;
  localparam int PHASE_W   = 4;
  localparam int CMD_W     = 3;
  localparam int BITCNT_W  = 4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_NONE     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WAIT_ACK = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_ACK      = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NACK     = 3'd7;

  // Sequencer phases
  localparam logic [PHASE_W-1:0] PH_IDLE = 4'd0;
  localparam logic [PHASE_W-1:0] PH_S1   = 4'd1;
  localparam logic [PHASE_W-1:0] PH_S2   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_P1   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_P2   = 4'd4;
  localparam logic [PHASE_W-1:0] PH_A1   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_A2   = 4'd6;
  localparam logic [PHASE_W-1:0] PH_POLL = 4'd7;
  localparam logic [PHASE_W-1:0] PH_W1   = 4'd8;
  localparam logic [PHASE_W-1:0] PH_W2   = 4'd9;
  localparam logic [PHASE_W-1:0] PH_W3   = 4'd10;
  localparam logic [PHASE_W-1:0] PH_R1   = 4'd11;
  localparam logic [PHASE_W-1:0] PH_R2   = 4'd12;
  localparam logic [PHASE_W-1:0] PH_K1   = 4'd13;
  localparam logic [PHASE_W-1:0] PH_K2   = 4'd14;

  // Configuration register indexes
  localparam logic REG_TICKS_PER_US   = 1'b0;
  localparam logic REG_ACK_POLL_LIMIT = 1'b1;

  localparam logic [7:0] TICKS_PER_US_RST   = 8'd1;
  localparam logic [7:0] ACK_POLL_LIMIT_RST = 8'd250;

  typedef struct packed {
    logic [7:0] ticks_per_us;
    logic [7:0] ack_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [DATA_BITS-1:0] tx_byte;
    logic                 send_ack;
    logic                 sda_sample;
  } item_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 sda_drive_enable;
    logic                 busy_res;
    logic                 done_res;
    logic [DATA_BITS-1:0] rx_byte;
    logic                 nack;
  } res_t;

  // Hold length in ticks: ticks_per_us scaled by 1, 2 or 4 (shift 0, 1, 2).
  function automatic logic [HOLD_W-1:0] hold_ticks(input logic [1:0] shift,
                                                   input logic [7:0] tpu);
    logic [HOLD_W-1:0] eff;
    eff = (tpu == 8'd0) ? HOLD_W'(1) : HOLD_W'(tpu);
    return eff << shift;
  endfunction

endpackage

`default_nettype wire

// File: sv/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master pin sequencer: one timebase tick in, one line-drive result out.
// ----------------------------------------------------------------------------
// Each input item is one timebase tick; the block takes one item per clock
// unless the output stalls, and returns exactly one result per item via an
// input register, then the step logic into the output register. Hold times
// are counted in items, not clocks: a segment lasts 1, 2 or 4 times
// ticks_per_us ticks. The input side keeps flowing while the output register
// holds an untaken result, and stalls only when both registers are full.
`default_nettype none

module i2c_master_bit_sequencer
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] cmd, [10:3] tx_byte, [11] send_ack, [12] sda_sample, [15:13] zero
  input  wire logic [15:0] s_axis_tdata,
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive_enable, [3] busy_res,
  // [4] done_res, [12:5] rx_byte, [13] nack, [15:14] zero
  output logic [15:0]      m_axis_tdata
);

  cfg_t  cfg;
  logic  in_valid;
  item_t in_item;
  logic  advance;
  res_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_us   <= TICKS_PER_US_RST;
      cfg.ack_poll_limit <= ACK_POLL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TICKS_PER_US:   cfg.ticks_per_us   <= cfg_data;
        REG_ACK_POLL_LIMIT: cfg.ack_poll_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.cmd        <= s_axis_tdata[2:0];
      in_item.tx_byte    <= s_axis_tdata[10:3];
      in_item.send_ack   <= s_axis_tdata[11];
      in_item.sda_sample <= s_axis_tdata[12];
    end
  end

  i2cm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {2'b00, res.nack, res.rx_byte, res.done_res, res.busy_res,
                       res.sda_drive_enable, res.sda_level, res.scl_level};
    end
  end

endmodule

`default_nettype wire

// File: sv/i2cm_core.sv
// ----------------------------------------------------------------------------
// i2cm_core
// Sequencer state and the per-tick step: one item in, next line drive and
// status out, state advanced when step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_core
  import i2cm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  step,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output res_t       res
);

  localparam logic [BITCNT_W-1:0] BIT_LAST = BITCNT_W'(DATA_BITS);

  logic [PHASE_W-1:0]   phase,      phase_next;
  logic [BITCNT_W-1:0]  bit_count,  bit_count_next;
  logic [HOLD_W-1:0]    hold_count, hold_count_next;
  logic [7:0]           poll_count, poll_count_next;
  logic [DATA_BITS-1:0] shift_reg,  shift_reg_next;
  logic                 ack_choice, ack_choice_next;
  logic                 scl,        scl_next;
  logic                 sda,        sda_next;
  logic                 oe,         oe_next;
  logic [DATA_BITS-1:0] rx_last,    rx_last_next;
  logic                 nack_flag,  nack_flag_next;
  logic                 done;

  logic [HOLD_W-1:0]   h1, h2, h4, hold_dec;
  logic [BITCNT_W-1:0] bit_inc;

  assign h1       = hold_ticks(2'd0, cfg.ticks_per_us);
  assign h2       = hold_ticks(2'd1, cfg.ticks_per_us);
  assign h4       = hold_ticks(2'd2, cfg.ticks_per_us);
  assign hold_dec = (hold_count != '0) ? hold_count - HOLD_W'(1) : hold_count;
  assign bit_inc  = bit_count + BITCNT_W'(1);

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    hold_count_next = hold_count;
    poll_count_next = poll_count;
    shift_reg_next  = shift_reg;
    ack_choice_next = ack_choice;
    scl_next        = scl;
    sda_next        = sda;
    oe_next         = oe;
    rx_last_next    = rx_last;
    nack_flag_next  = nack_flag;
    done            = 1'b0;

    case (phase)
      PH_IDLE: begin
        case (item.cmd)
          CMD_START: begin
            scl_next = 1'b1; sda_next = 1'b1; oe_next = 1'b1;
            hold_count_next = h4; phase_next = PH_S1;
          end
          CMD_STOP: begin
            scl_next = 1'b0; sda_next = 1'b0; oe_next = 1'b1;
            hold_count_next = h4; phase_next = PH_P1;
          end
          CMD_WRITE: begin
            bit_count_next = '0;
            scl_next = 1'b0; sda_next = item.tx_byte[DATA_BITS-1]; oe_next = 1'b1;
            shift_reg_next = {item.tx_byte[DATA_BITS-2:0], 1'b0};
            hold_count_next = h2; phase_next = PH_W1;
          end
          CMD_WAIT_ACK: begin
            nack_flag_next = 1'b0;
            sda_next = 1'b1; oe_next = 1'b0;
            hold_count_next = h1; phase_next = PH_A1;
          end
          CMD_READ: begin
            ack_choice_next = item.send_ack;
            bit_count_next = '0; shift_reg_next = '0;
            scl_next = 1'b0; oe_next = 1'b0;
            hold_count_next = h2; phase_next = PH_R1;
          end
          CMD_ACK: begin
            scl_next = 1'b0; sda_next = 1'b0; oe_next = 1'b1;
            hold_count_next = h2; phase_next = PH_K1;
          end
          CMD_NACK: begin
            scl_next = 1'b0; sda_next = 1'b1; oe_next = 1'b1;
            hold_count_next = h2; phase_next = PH_K1;
          end
          default: ;
        endcase
      end

      PH_POLL: begin
        if (!item.sda_sample) begin
          scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
        end else if (poll_count >= cfg.ack_poll_limit) begin
          // timed out: flag it and run a stop
          nack_flag_next = 1'b1;
          scl_next = 1'b0; sda_next = 1'b0; oe_next = 1'b1;
          hold_count_next = h4; phase_next = PH_P1;
        end else begin
          poll_count_next = poll_count + 8'd1;
        end
      end

      default: begin
        hold_count_next = hold_dec;
        if (hold_dec == '0) begin
          case (phase)
            PH_S1: begin
              scl_next = 1'b1; sda_next = 1'b0; oe_next = 1'b1;
              hold_count_next = h4; phase_next = PH_S2;
            end
            PH_S2: begin
              scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
            end
            PH_P1: begin
              scl_next = 1'b1; sda_next = 1'b1; oe_next = 1'b1;
              hold_count_next = h4; phase_next = PH_P2;
            end
            PH_P2: begin
              phase_next = PH_IDLE; done = 1'b1;
            end
            PH_A1: begin
              scl_next = 1'b1; oe_next = 1'b0;
              hold_count_next = h1; phase_next = PH_A2;
            end
            PH_A2: begin
              phase_next = PH_POLL; poll_count_next = '0;
            end
            PH_W1: begin
              scl_next = 1'b1; oe_next = 1'b1;
              hold_count_next = h2; phase_next = PH_W2;
            end
            PH_W2: begin
              scl_next = 1'b0; oe_next = 1'b1;
              hold_count_next = h2; phase_next = PH_W3;
            end
            PH_W3: begin
              bit_count_next = bit_inc;
              if (bit_inc >= BIT_LAST) begin
                phase_next = PH_IDLE; done = 1'b1;
              end else begin
                scl_next = 1'b0; sda_next = shift_reg[DATA_BITS-1]; oe_next = 1'b1;
                shift_reg_next = {shift_reg[DATA_BITS-2:0], 1'b0};
                hold_count_next = h2; phase_next = PH_W1;
              end
            end
            PH_R1: begin
              shift_reg_next = {shift_reg[DATA_BITS-2:0], item.sda_sample};
              scl_next = 1'b1; oe_next = 1'b0;
              hold_count_next = h1; phase_next = PH_R2;
            end
            PH_R2: begin
              bit_count_next = bit_inc;
              if (bit_inc >= BIT_LAST) begin
                rx_last_next = shift_reg;
                scl_next = 1'b0; sda_next = !ack_choice; oe_next = 1'b1;
                hold_count_next = h2; phase_next = PH_K1;
              end else begin
                scl_next = 1'b0; oe_next = 1'b0;
                hold_count_next = h2; phase_next = PH_R1;
              end
            end
            PH_K1: begin
              scl_next = 1'b1; oe_next = 1'b1;
              hold_count_next = h2; phase_next = PH_K2;
            end
            PH_K2: begin
              scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
            end
            default: phase_next = PH_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= '0;
      hold_count <= '0;
      poll_count <= '0;
      shift_reg  <= '0;
      ack_choice <= 1'b0;
      scl        <= 1'b1;
      sda        <= 1'b1;
      oe         <= 1'b1;
      rx_last    <= '0;
      nack_flag  <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      hold_count <= hold_count_next;
      poll_count <= poll_count_next;
      shift_reg  <= shift_reg_next;
      ack_choice <= ack_choice_next;
      scl        <= scl_next;
      sda        <= sda_next;
      oe         <= oe_next;
      rx_last    <= rx_last_next;
      nack_flag  <= nack_flag_next;
    end
  end

  always_comb begin
    res.scl_level        = scl_next;
    res.sda_level        = sda_next;
    res.sda_drive_enable = oe_next;
    res.busy_res         = (phase_next != PH_IDLE);
    res.done_res         = done;
    res.rx_byte          = rx_last_next;
    res.nack             = nack_flag_next;
  end

endmodule

`default_nettype wire

// File: sv/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the I2C master bit sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // no result straight after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

  // input stalls only behind a result that is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with output register empty");

  // a completing command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[3])
    else $error("done reported while still busy");

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind i2c_master_bit_sequencer i2cm_checker u_i2cm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
